// ===== rtl/core/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg
// Types and constants shared by the plant response classifier modules.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int GAIN_W      = 24;
    localparam int CODES_W     = 32;
    localparam int RUN_W       = 8;
    localparam int RESP_W      = 49;
    localparam int PROD_W      = CODES_W + GAIN_W;
    localparam int OUT_TDATA_W = ((2 * RESP_W + RUN_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 6;
    localparam int IN_TUSER_W  = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_MIN      = 3'd0,
        CFG_GAIN_MAX      = 3'd1,
        CFG_DETECT_FLOOR  = 3'd2,
        CFG_WSIGN_FLOOR   = 3'd3,
        CFG_GROWTH_MARGIN = 3'd4,
        CFG_EXCESS_MARGIN = 3'd5,
        CFG_MAX_IND_RUN   = 3'd6
    } t_cfg_idx;

    localparam logic [GAIN_W-1:0]     GAIN_MIN_RST      = 24'd702548;
    localparam logic [GAIN_W-1:0]     GAIN_MAX_RST      = 24'd744494;
    localparam logic [31:0]           DETECT_FLOOR_RST  = 32'd14316551;
    localparam logic [31:0]           WSIGN_FLOOR_RST   = 32'd14316551;
    localparam logic [31:0]           GROWTH_MARGIN_RST = 32'd26843527;
    localparam logic [31:0]           EXCESS_MARGIN_RST = 32'd26843527;
    localparam logic [RUN_W-1:0]      MAX_IND_RUN_RST   = 8'd2;
    localparam logic [RUN_W-1:0]      RUN_SAT           = 8'hFF;

    typedef enum logic [2:0] {
        CLS_DETECTED      = 3'd0,
        CLS_INDETERMINATE = 3'd1,
        CLS_WRONG_SIGN    = 3'd2,
        CLS_EXCESS        = 3'd3,
        CLS_GROWING       = 3'd4,
        CLS_FAULT         = 3'd5
    } t_class;

    typedef enum logic [2:0] {
        RSN_INVALID     = 3'd0,
        RSN_OVERFLOW    = 3'd1,
        RSN_WRONG_SIGN  = 3'd2,
        RSN_GROWTH      = 3'd3,
        RSN_EXCESS      = 3'd4,
        RSN_DETECTED    = 3'd5,
        RSN_ABSENCE     = 3'd6,
        RSN_BELOW_FLOOR = 3'd7
    } t_reason;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_min_per_code;
        logic [GAIN_W-1:0] gain_max_per_code;
        logic [31:0]       detection_floor;
        logic [31:0]       wrong_sign_floor;
        logic [31:0]       growth_margin;
        logic [31:0]       excess_margin;
        logic [RUN_W-1:0]  max_indeterminate_run;
    } t_cfg;

    typedef struct packed {
        t_class                   response_class;
        t_reason                  reason_code;
        logic signed [RESP_W-1:0] step_response;
        logic signed [RESP_W-1:0] total_response;
        logic [RUN_W-1:0]         indeterminate_run;
    } t_result;

endpackage

// ===== rtl/core/prc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// prc_cfg_regs
// Configuration register file, write only, reset to the nominal plant values.
// ----------------------------------------------------------------------------
module prc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [prc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output prc_pkg::t_cfg                 o_cfg
);
    import prc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_min_per_code     <= GAIN_MIN_RST;
            r_cfg.gain_max_per_code     <= GAIN_MAX_RST;
            r_cfg.detection_floor       <= DETECT_FLOOR_RST;
            r_cfg.wrong_sign_floor      <= WSIGN_FLOOR_RST;
            r_cfg.growth_margin         <= GROWTH_MARGIN_RST;
            r_cfg.excess_margin         <= EXCESS_MARGIN_RST;
            r_cfg.max_indeterminate_run <= MAX_IND_RUN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_MIN:      r_cfg.gain_min_per_code     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_MAX:      r_cfg.gain_max_per_code     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_DETECT_FLOOR:  r_cfg.detection_floor       <= i_cfg_wdata;
                CFG_WSIGN_FLOOR:   r_cfg.wrong_sign_floor      <= i_cfg_wdata;
                CFG_GROWTH_MARGIN: r_cfg.growth_margin         <= i_cfg_wdata;
                CFG_EXCESS_MARGIN: r_cfg.excess_margin         <= i_cfg_wdata;
                CFG_MAX_IND_RUN:   r_cfg.max_indeterminate_run <= i_cfg_wdata[RUN_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/prc_classify.sv =====
// ----------------------------------------------------------------------------
// prc_classify
// Tracking state and single-pass classification of one registered item.
// ----------------------------------------------------------------------------
module prc_classify #(
    parameter int ERROR_WIDTH = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  prc_pkg::t_cfg                       i_cfg,
    input  logic signed [ERROR_WIDTH-1:0]       i_error_before,
    input  logic signed [ERROR_WIDTH-1:0]       i_error_after,
    input  logic signed [prc_pkg::CODES_W-1:0]  i_correction_codes,
    input  logic                                i_evidence_ok,
    input  logic                                i_observe_only,
    output prc_pkg::t_result                    o_result
);
    import prc_pkg::*;

    localparam int EW = ERROR_WIDTH;
    // compare width: covers the envelope sum and the error magnitudes
    localparam int CW = (EW + 2 > PROD_W + 2) ? EW + 2 : PROD_W + 2;

    logic                      r_base_valid;
    logic signed [EW-1:0]      r_base_err;
    logic signed [CODES_W-1:0] r_total_corr;
    logic [RUN_W-1:0]          r_ind_cnt;

    logic                      n_base_valid;
    logic signed [EW-1:0]      n_base_err;
    logic signed [CODES_W-1:0] n_total_corr;
    logic [RUN_W-1:0]          n_ind_cnt;

    logic signed [EW-1:0]      base_eff;
    logic                      invalid;
    logic signed [CODES_W:0]   sum;
    logic                      ovf;
    logic signed [CODES_W-1:0] tc_new;
    logic signed [EW:0]        step;
    logic signed [EW:0]        total;
    logic signed [63:0]        step_ext;
    logic signed [63:0]        total_ext;
    logic [EW:0]               smag;
    logic [EW:0]               tmag;
    logic [EW-1:0]             amag;
    logic [EW-1:0]             bmag;
    logic [CODES_W-1:0]        cmag;
    logic [CODES_W-1:0]        tcmag;
    logic [PROD_W-1:0]         prod_max;
    logic [PROD_W-1:0]         prod_min;
    logic                      step_pos, step_neg, tot_pos, tot_neg;
    logic                      cod_pos, cod_neg, tc_pos, tc_neg;
    logic                      wrong, grow, excess, detect, expect_ok, fault;
    logic [RUN_W-1:0]          cnt_inc;

    always_comb begin
        base_eff = r_base_valid ? r_base_err : i_error_before;
        invalid  = !i_evidence_ok || (i_correction_codes == '0);

        sum    = {r_total_corr[CODES_W-1], r_total_corr}
               + {i_correction_codes[CODES_W-1], i_correction_codes};
        ovf    = sum[CODES_W] ^ sum[CODES_W-1];
        tc_new = sum[CODES_W-1:0];

        step  = {i_error_after[EW-1], i_error_after} - {i_error_before[EW-1], i_error_before};
        total = {i_error_after[EW-1], i_error_after} - {base_eff[EW-1], base_eff};
        step_ext  = 64'(step);
        total_ext = 64'(total);

        smag  = step[EW]  ? (~step) + 1'b1 : step;
        tmag  = total[EW] ? (~total) + 1'b1 : total;
        amag  = i_error_after[EW-1]  ? (~i_error_after) + 1'b1  : i_error_after;
        bmag  = i_error_before[EW-1] ? (~i_error_before) + 1'b1 : i_error_before;
        cmag  = i_correction_codes[CODES_W-1] ? (~i_correction_codes) + 1'b1
                                              : i_correction_codes;
        tcmag = tc_new[CODES_W-1] ? (~tc_new) + 1'b1 : tc_new;

        prod_max = PROD_W'(cmag)  * PROD_W'(i_cfg.gain_max_per_code);
        prod_min = PROD_W'(tcmag) * PROD_W'(i_cfg.gain_min_per_code);

        // a zero value is neither positive nor negative
        step_neg = step[EW];
        step_pos = !step[EW] && (step != '0);
        tot_neg  = total[EW];
        tot_pos  = !total[EW] && (total != '0);
        cod_neg  = i_correction_codes[CODES_W-1];
        cod_pos  = !i_correction_codes[CODES_W-1] && (i_correction_codes != '0);
        tc_neg   = tc_new[CODES_W-1];
        tc_pos   = !tc_new[CODES_W-1] && (tc_new != '0);

        wrong  = (((step_pos && cod_neg) || (step_neg && cod_pos))
                  && (CW'(smag) >= CW'(i_cfg.wrong_sign_floor)))
              || (((tot_pos && tc_neg) || (tot_neg && tc_pos))
                  && (CW'(tmag) >= CW'(i_cfg.wrong_sign_floor)));
        grow   = CW'(amag) > (CW'(bmag) + CW'(i_cfg.growth_margin));
        excess = CW'(smag) > (CW'(prod_max) + CW'(i_cfg.excess_margin));
        detect = (((step_pos && cod_pos) || (step_neg && cod_neg))
                  && (CW'(smag) >= CW'(i_cfg.detection_floor)))
              || (((tot_pos && tc_pos) || (tot_neg && tc_neg))
                  && (CW'(tmag) >= CW'(i_cfg.detection_floor)));

        cnt_inc   = (r_ind_cnt == RUN_SAT) ? r_ind_cnt : r_ind_cnt + 1'b1;
        expect_ok = prod_min >= PROD_W'({i_cfg.detection_floor, 1'b0});
        fault     = !i_observe_only && (cnt_inc > i_cfg.max_indeterminate_run) && expect_ok;

        n_base_valid = r_base_valid;
        n_base_err   = r_base_err;
        n_total_corr = r_total_corr;
        n_ind_cnt    = r_ind_cnt;

        o_result.response_class    = CLS_FAULT;
        o_result.reason_code       = RSN_INVALID;
        o_result.step_response     = '0;
        o_result.total_response    = '0;
        o_result.indeterminate_run = '0;

        if (invalid) begin
            n_ind_cnt = '0;
        end else begin
            n_base_valid = 1'b1;
            n_base_err   = base_eff;
            if (ovf) begin
                o_result.reason_code       = RSN_OVERFLOW;
                o_result.indeterminate_run = r_ind_cnt;
            end else begin
                n_total_corr = tc_new;
                o_result.step_response  = step_ext[RESP_W-1:0];
                o_result.total_response = total_ext[RESP_W-1:0];
                if (wrong) begin
                    n_ind_cnt = '0;
                    o_result.response_class = CLS_WRONG_SIGN;
                    o_result.reason_code    = RSN_WRONG_SIGN;
                end else if (grow) begin
                    n_ind_cnt = '0;
                    o_result.response_class = CLS_GROWING;
                    o_result.reason_code    = RSN_GROWTH;
                end else if (excess) begin
                    n_ind_cnt = '0;
                    o_result.response_class = CLS_EXCESS;
                    o_result.reason_code    = RSN_EXCESS;
                end else if (detect) begin
                    n_ind_cnt = '0;
                    o_result.response_class = CLS_DETECTED;
                    o_result.reason_code    = RSN_DETECTED;
                end else begin
                    n_ind_cnt = cnt_inc;
                    if (fault) begin
                        o_result.response_class = CLS_FAULT;
                        o_result.reason_code    = RSN_ABSENCE;
                    end else begin
                        o_result.response_class = CLS_INDETERMINATE;
                        o_result.reason_code    = RSN_BELOW_FLOOR;
                    end
                end
                o_result.indeterminate_run = n_ind_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_valid <= 1'b0;
            r_total_corr <= '0;
            r_ind_cnt    <= '0;
        end else if (i_en) begin
            r_base_valid <= n_base_valid;
            r_total_corr <= n_total_corr;
            r_ind_cnt    <= n_ind_cnt;
        end
    end

    // baseline is read only once valid
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base_err <= n_base_err;
        end
    end

endmodule

// ===== rtl/core/plant_response_classifier.sv =====
// ----------------------------------------------------------------------------
// plant_response_classifier
// Classifies the frequency plant's answer to each actuator correction.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the stage 1 input register until the result
//   register is free or being emptied, then its result is registered there.
// Throughput: one item per cycle; the only stall is the result register
//   being full while the downstream side holds tready low.
// Reset (i_rst_n low, synchronous): both pipeline stages empty, baseline
//   invalid, cumulative correction and indeterminate run zero, all
//   configuration registers back to their nominal values.
module plant_response_classifier #(
    parameter int ERROR_WIDTH = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [prc_pkg::CFG_DATA_W-1:0]         i_cfg_wdata,
    // item input
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: error_before, error_after, correction_codes, zero fill
    input  logic [((2*ERROR_WIDTH+32+7)/8)*8-1:0] s_axis_tdata,
    // tuser: evidence_ok, observe_only
    input  logic [prc_pkg::IN_TUSER_W-1:0]         s_axis_tuser,
    // result output
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: step_response, total_response, indeterminate_run, zero fill
    output logic [prc_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // tuser: response_class, reason_code
    output logic [prc_pkg::OUT_TUSER_W-1:0]        m_axis_tuser
);
    import prc_pkg::*;

    localparam int EW    = ERROR_WIDTH;
    localparam int PAD_W = OUT_TDATA_W - 2 * RESP_W - RUN_W;

    t_cfg    cfg;
    t_result result;

    // stage 1: accepted item waiting for classification
    logic                      r_s1_valid;
    logic signed [EW-1:0]      r_err_before;
    logic signed [EW-1:0]      r_err_after;
    logic signed [CODES_W-1:0] r_codes;
    logic                      r_ok;
    logic                      r_observe;

    // stage 2: finished result waiting for the downstream side
    logic    r_out_valid;
    t_result r_out;

    logic advance;

    // classify when a result slot is free or is being emptied this cycle;
    // the tracking state steps only here so each item updates it once
    assign advance       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || advance;

    prc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    prc_classify #(
        .ERROR_WIDTH (ERROR_WIDTH)
    ) u_classify (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (advance),
        .i_cfg              (cfg),
        .i_error_before     (r_err_before),
        .i_error_after      (r_err_after),
        .i_correction_codes (r_codes),
        .i_evidence_ok      (r_ok),
        .i_observe_only     (r_observe),
        .o_result           (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_err_before <= s_axis_tdata[EW-1:0];
            r_err_after  <= s_axis_tdata[2*EW-1:EW];
            r_codes      <= s_axis_tdata[2*EW+CODES_W-1:2*EW];
            r_ok         <= s_axis_tuser[0];
            r_observe    <= s_axis_tuser[1];
        end
    end

    // result register: fill on advance, empty when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out.indeterminate_run,
                            r_out.total_response, r_out.step_response};
    assign m_axis_tuser  = {r_out.reason_code, r_out.response_class};

endmodule
